/* rtl/hfr_pkg.sv */
// Package for the HDLC frame receiver: framing constants, frame kinds,
// the result record and the bytewise CRC-16/X.25 update.
// No dependencies.
package hfr_pkg;

    localparam int unsigned FRAME_BYTES_DEFAULT = 256;
    localparam int unsigned LENGTH_W = 9;

    localparam logic [7:0]  FLAG_BYTE        = 8'h7E;
    localparam logic [7:0]  ESCAPE_BYTE      = 8'h7D;
    localparam logic [7:0]  ESCAPE_XOR       = 8'h20;
    localparam logic [7:0]  ERROR_ADDRESS    = 8'hEE;
    localparam logic [15:0] CRC_SEED         = 16'hFFFF;
    localparam logic [15:0] CRC_GOOD_RESIDUE = 16'hF0B8;

    localparam logic [7:0] CONTROL_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] SERIAL_ADDRESS_RESET  = 8'h05;

    typedef enum logic {
        REG_CONTROL_ADDRESS = 1'b0,
        REG_SERIAL_ADDRESS  = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_ERROR_MARKER = 3'd0,
        KIND_ACK          = 3'd1,
        KIND_CONTROL      = 3'd2,
        KIND_CDC_IGNORED  = 3'd3,
        KIND_BAD_ADDRESS  = 3'd4,
        KIND_BAD_CRC_LEN  = 3'd5
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t         frame_kind;
        logic [7:0]          address;
        logic [7:0]          control;
        logic [2:0]          ack_seq;
        logic [7:0]          command;
        logic [LENGTH_W-1:0] frame_length;
        logic [15:0]         crc_value;
    } hfr_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] e;
        logic [7:0] f;
        e = crc[7:0] ^ b;
        f = e ^ {e[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {f, 8'h00} ^ {5'b00000, f, 3'b000}
               ^ {12'h000, f[7:4]};
    endfunction

endpackage

/* rtl/hfr_deframe_core.sv */
// Deframing core: escape handling, running CRC, byte count, held header
// bytes and frame classification at the flag byte.
// Depends on hfr_pkg.
module hfr_deframe_core
    import hfr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  control_address,
    input  logic [7:0]  serial_address,
    output logic        frame_end,
    output hfr_result_t result
);

    localparam int unsigned COUNT_W = $clog2(FRAME_BYTES + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(FRAME_BYTES);

    logic               escape_reg, escape_next;
    logic [15:0]        crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         address_reg, address_next;
    logic [7:0]         control_reg, control_next;
    logic [7:0]         command_reg, command_next;

    logic               is_flag;
    logic               is_escape;
    logic [7:0]         plain_byte;
    logic [COUNT_W-1:0] slot;
    logic [7:0]         ctl;
    logic               crc_len_ok;

    assign is_flag   = (data_byte == FLAG_BYTE);
    assign is_escape = (data_byte == ESCAPE_BYTE);
    assign frame_end = is_flag && (count_reg != '0);
    assign plain_byte = escape_reg ? (data_byte ^ ESCAPE_XOR) : data_byte;

    always_comb
    begin
        escape_next  = escape_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        address_next = address_reg;
        control_next = control_reg;
        command_next = command_reg;
        slot         = count_reg;
        if (step)
        begin
            if (is_flag)
            begin
                if (count_reg != '0)
                begin
                    crc_next   = CRC_SEED;
                    count_next = '0;
                end
            end
            else if (is_escape)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                escape_next = 1'b0;
                if (count_reg >= COUNT_MAX)
                begin
                    slot     = '0;
                    crc_next = CRC_SEED;
                end
                else
                begin
                    crc_next = crc_byte(crc_reg, plain_byte);
                end
                if (slot == COUNT_W'(0))
                    address_next = plain_byte;
                else if (slot == COUNT_W'(1))
                    control_next = plain_byte;
                else if (slot == COUNT_W'(3))
                    command_next = plain_byte;
                count_next = slot + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= 1'b0;
            crc_reg     <= CRC_SEED;
            count_reg   <= '0;
            address_reg <= '0;
            control_reg <= '0;
            command_reg <= '0;
        end
        else
        begin
            escape_reg  <= escape_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            address_reg <= address_next;
            control_reg <= control_next;
            command_reg <= command_next;
        end
    end

    assign ctl        = (count_reg >= COUNT_W'(2)) ? control_reg : 8'h00;
    assign crc_len_ok = (count_reg > COUNT_W'(3)) && (crc_reg == CRC_GOOD_RESIDUE);

    always_comb
    begin
        result.address      = address_reg;
        result.control      = ctl;
        result.command      = (count_reg >= COUNT_W'(4)) ? command_reg : 8'h00;
        result.frame_length = LENGTH_W'(count_reg);
        result.crc_value    = crc_reg;
        result.ack_seq      = 3'b000;
        if (address_reg == ERROR_ADDRESS)
            result.frame_kind = KIND_ERROR_MARKER;
        else if (!crc_len_ok)
            result.frame_kind = KIND_BAD_CRC_LEN;
        else if (!ctl[0])
        begin
            result.frame_kind = KIND_ACK;
            result.ack_seq    = ctl[7:5];
        end
        else if ((address_reg == control_address) && (count_reg > COUNT_W'(9)))
            result.frame_kind = KIND_CONTROL;
        else if (address_reg == serial_address)
            result.frame_kind = KIND_CDC_IGNORED;
        else
            result.frame_kind = KIND_BAD_ADDRESS;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("byte count beyond frame size");

    a_flag_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_end |=> count_reg == '0 && crc_reg == CRC_SEED)
        else $error("frame state not restarted after flag");

    a_escape_arms: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_escape |=> escape_reg)
        else $error("escape not armed");

    a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && !is_flag && !is_escape |=> count_reg != '0 && !escape_reg)
        else $error("data byte not counted");

endmodule

/* rtl/hfr_result_reg.sv */
// Output register for frame results with stream handshake.
// Depends on hfr_pkg.
module hfr_result_reg
    import hfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  hfr_result_t load_data,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output hfr_result_t out_data
);

    logic        valid_reg, valid_next;
    hfr_result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/hdlc_frame_receiver_unit.sv */
// HDLC frame receiver top level: input register, configuration registers,
// deframing core and result register.
// Depends on hfr_pkg, hfr_deframe_core, hfr_result_reg.
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         s_tvalid / s_tready      one raw serial byte
//  m_axis    out        m_tvalid / m_tready      one frame result at each closing flag
//  cfg       in         cfg_we                   control_address, serial_address
//
//  One byte per cycle unless a closing flag waits; bytes pass through the input
//  register, and a result appears in the cycle after its flag byte is processed.
//  Reset clears all framing state and restores the register defaults.
//  A flag byte that closes a frame waits in the input register while the
//  result register is full and not taken; other bytes keep flowing.
module hdlc_frame_receiver_unit
    import hfr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] address, [15:8] control, [18:16] ack_seq,
                                   // [26:19] command, [35:27] frame_length,
                                   // [51:36] crc_value, [55:52] zero
    output logic [2:0]  m_tuser,   // [2:0] frame_kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [7:0]  ctrl_addr_reg;
    logic [7:0]  serial_addr_reg;
    logic        step;
    logic        frame_end;
    logic        out_free;
    hfr_result_t core_result;
    hfr_result_t out_result;

    assign step     = in_valid_reg && (!frame_end || out_free);
    assign s_tready = !in_valid_reg || step;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_addr_reg   <= CONTROL_ADDRESS_RESET;
            serial_addr_reg <= SERIAL_ADDRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CONTROL_ADDRESS: ctrl_addr_reg   <= cfg_data;
                REG_SERIAL_ADDRESS:  serial_addr_reg <= cfg_data;
                default:             ctrl_addr_reg   <= ctrl_addr_reg;
            endcase
        end
    end

    hfr_deframe_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .control_address (ctrl_addr_reg),
        .serial_address  (serial_addr_reg),
        .frame_end       (frame_end),
        .result          (core_result)
    );

    hfr_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && frame_end),
        .load_data (core_result),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tuser = out_result.frame_kind;
    assign m_tdata = {4'b0000, out_result.crc_value, out_result.frame_length,
                      out_result.command, out_result.ack_seq, out_result.control,
                      out_result.address};

endmodule
